[sv/qr_codeword_interleaver_defines.svh]
// assertion macros shared by the interleaver rtl files
// depends on clk_i and rst_ni being declared in the module that uses them
`ifndef QR_CODEWORD_INTERLEAVER_DEFINES_SVH
`define QR_CODEWORD_INTERLEAVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset only
`define QCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define QCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QCI_ASSERT(lbl, prop, msg)
`define QCI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/qci_pkg.sv]
// shared types, codes and block tables of the qr codeword interleaver
// no dependencies; imported by every module of the block but qci_ram
`default_nettype none

package qci_pkg;

  localparam int unsigned StoreDepthDef = 4096;
  localparam int unsigned NumVersions   = 40;
  localparam int unsigned QueueDepth    = 2;

  // opcodes carried in tuser
  typedef enum logic [1:0] {
    OpWrData  = 2'd0,
    OpWrEc    = 2'd1,
    OpRead    = 2'd2,
    OpRestart = 2'd3
  } opcode_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    RegVersion = 1'b0,
    RegEcLevel = 1'b1
  } reg_idx_e;

  // one block table entry: group 1 blocks, data bytes per group 1 block, group 2 blocks
  typedef struct packed {
    logic [6:0] g1;
    logic [6:0] k;
    logic [6:0] g2;
  } blk_t;

  // symbol geometry derived from the configuration
  typedef struct packed {
    logic [6:0]  g1;
    logic [6:0]  k;
    logic [6:0]  g2;
    logic [7:0]  nb;
    logic [11:0] g1k;
    logic [11:0] l;
    logic [4:0]  e;
    logic [12:0] nbe;
  } geom_t;

  // one store access queued between front and back
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic        zero;
    logic        last;
    logic [11:0] addr;
    logic [7:0]  data;
  } cmd_t;

  // total codewords per version
  localparam logic [11:0] SymTotal [NumVersions] = '{
    12'd26,   12'd44,   12'd70,   12'd100,  12'd134,  12'd172,  12'd196,  12'd242,
    12'd292,  12'd346,  12'd404,  12'd466,  12'd532,  12'd581,  12'd655,  12'd733,
    12'd815,  12'd901,  12'd991,  12'd1085, 12'd1156, 12'd1258, 12'd1364, 12'd1474,
    12'd1588, 12'd1706, 12'd1828, 12'd1921, 12'd2051, 12'd2185, 12'd2323, 12'd2465,
    12'd2611, 12'd2761, 12'd2876, 12'd3034, 12'd3196, 12'd3362, 12'd3532, 12'd3706
  };

  // block structure per version and ec level (L, M, Q, H)
  localparam blk_t BlkRom [NumVersions][4] = '{
    '{'{7'd1,7'd19,7'd0},   '{7'd1,7'd16,7'd0},   '{7'd1,7'd13,7'd0},   '{7'd1,7'd9,7'd0}},
    '{'{7'd1,7'd34,7'd0},   '{7'd1,7'd28,7'd0},   '{7'd1,7'd22,7'd0},   '{7'd1,7'd16,7'd0}},
    '{'{7'd1,7'd55,7'd0},   '{7'd1,7'd44,7'd0},   '{7'd2,7'd17,7'd0},   '{7'd2,7'd13,7'd0}},
    '{'{7'd1,7'd80,7'd0},   '{7'd2,7'd32,7'd0},   '{7'd2,7'd24,7'd0},   '{7'd4,7'd9,7'd0}},
    '{'{7'd1,7'd108,7'd0},  '{7'd2,7'd43,7'd0},   '{7'd2,7'd15,7'd2},   '{7'd2,7'd11,7'd2}},
    '{'{7'd2,7'd68,7'd0},   '{7'd4,7'd27,7'd0},   '{7'd4,7'd19,7'd0},   '{7'd4,7'd15,7'd0}},
    '{'{7'd2,7'd78,7'd0},   '{7'd4,7'd31,7'd0},   '{7'd2,7'd14,7'd4},   '{7'd4,7'd13,7'd1}},
    '{'{7'd2,7'd97,7'd0},   '{7'd2,7'd38,7'd2},   '{7'd4,7'd18,7'd2},   '{7'd4,7'd14,7'd2}},
    '{'{7'd2,7'd116,7'd0},  '{7'd3,7'd36,7'd2},   '{7'd4,7'd16,7'd4},   '{7'd4,7'd12,7'd4}},
    '{'{7'd2,7'd68,7'd2},   '{7'd4,7'd43,7'd1},   '{7'd6,7'd19,7'd2},   '{7'd6,7'd15,7'd2}},
    '{'{7'd4,7'd81,7'd0},   '{7'd1,7'd50,7'd4},   '{7'd4,7'd22,7'd4},   '{7'd3,7'd12,7'd8}},
    '{'{7'd2,7'd92,7'd2},   '{7'd6,7'd36,7'd2},   '{7'd4,7'd20,7'd6},   '{7'd7,7'd14,7'd4}},
    '{'{7'd4,7'd107,7'd0},  '{7'd8,7'd37,7'd1},   '{7'd8,7'd20,7'd4},   '{7'd12,7'd11,7'd4}},
    '{'{7'd3,7'd115,7'd1},  '{7'd4,7'd40,7'd5},   '{7'd11,7'd16,7'd5},  '{7'd11,7'd12,7'd5}},
    '{'{7'd5,7'd87,7'd1},   '{7'd5,7'd41,7'd5},   '{7'd5,7'd24,7'd7},   '{7'd11,7'd12,7'd7}},
    '{'{7'd5,7'd98,7'd1},   '{7'd7,7'd45,7'd3},   '{7'd15,7'd19,7'd2},  '{7'd3,7'd15,7'd13}},
    '{'{7'd1,7'd107,7'd5},  '{7'd10,7'd46,7'd1},  '{7'd1,7'd22,7'd15},  '{7'd2,7'd14,7'd17}},
    '{'{7'd5,7'd120,7'd1},  '{7'd9,7'd43,7'd4},   '{7'd17,7'd22,7'd1},  '{7'd2,7'd14,7'd19}},
    '{'{7'd3,7'd113,7'd4},  '{7'd3,7'd44,7'd11},  '{7'd17,7'd21,7'd4},  '{7'd9,7'd13,7'd16}},
    '{'{7'd3,7'd107,7'd5},  '{7'd3,7'd41,7'd13},  '{7'd15,7'd24,7'd5},  '{7'd15,7'd15,7'd10}},
    '{'{7'd4,7'd116,7'd4},  '{7'd17,7'd42,7'd0},  '{7'd17,7'd22,7'd6},  '{7'd19,7'd16,7'd6}},
    '{'{7'd2,7'd111,7'd7},  '{7'd17,7'd46,7'd0},  '{7'd7,7'd24,7'd16},  '{7'd34,7'd13,7'd0}},
    '{'{7'd4,7'd121,7'd5},  '{7'd4,7'd47,7'd14},  '{7'd11,7'd24,7'd14}, '{7'd16,7'd15,7'd14}},
    '{'{7'd6,7'd117,7'd4},  '{7'd6,7'd45,7'd14},  '{7'd11,7'd24,7'd16}, '{7'd30,7'd16,7'd2}},
    '{'{7'd8,7'd106,7'd4},  '{7'd8,7'd47,7'd13},  '{7'd7,7'd24,7'd22},  '{7'd22,7'd15,7'd13}},
    '{'{7'd10,7'd114,7'd2}, '{7'd19,7'd46,7'd4},  '{7'd28,7'd22,7'd6},  '{7'd33,7'd16,7'd4}},
    '{'{7'd8,7'd122,7'd4},  '{7'd22,7'd45,7'd3},  '{7'd8,7'd23,7'd26},  '{7'd12,7'd15,7'd28}},
    '{'{7'd3,7'd117,7'd10}, '{7'd3,7'd45,7'd23},  '{7'd4,7'd24,7'd31},  '{7'd11,7'd15,7'd31}},
    '{'{7'd7,7'd116,7'd7},  '{7'd21,7'd45,7'd7},  '{7'd1,7'd23,7'd37},  '{7'd19,7'd15,7'd26}},
    '{'{7'd5,7'd115,7'd10}, '{7'd19,7'd47,7'd10}, '{7'd15,7'd24,7'd25}, '{7'd23,7'd15,7'd25}},
    '{'{7'd13,7'd115,7'd3}, '{7'd2,7'd46,7'd29},  '{7'd42,7'd24,7'd1},  '{7'd23,7'd15,7'd28}},
    '{'{7'd17,7'd115,7'd0}, '{7'd10,7'd46,7'd23}, '{7'd10,7'd24,7'd35}, '{7'd19,7'd15,7'd35}},
    '{'{7'd17,7'd115,7'd1}, '{7'd14,7'd46,7'd21}, '{7'd29,7'd24,7'd19}, '{7'd11,7'd15,7'd46}},
    '{'{7'd13,7'd115,7'd6}, '{7'd14,7'd46,7'd23}, '{7'd44,7'd24,7'd7},  '{7'd59,7'd16,7'd1}},
    '{'{7'd12,7'd121,7'd7}, '{7'd12,7'd47,7'd26}, '{7'd39,7'd24,7'd14}, '{7'd22,7'd15,7'd41}},
    '{'{7'd6,7'd121,7'd14}, '{7'd6,7'd47,7'd34},  '{7'd46,7'd24,7'd10}, '{7'd2,7'd15,7'd64}},
    '{'{7'd17,7'd122,7'd4}, '{7'd29,7'd46,7'd14}, '{7'd49,7'd24,7'd10}, '{7'd24,7'd15,7'd46}},
    '{'{7'd4,7'd122,7'd18}, '{7'd13,7'd46,7'd32}, '{7'd48,7'd24,7'd14}, '{7'd42,7'd15,7'd32}},
    '{'{7'd20,7'd117,7'd4}, '{7'd40,7'd47,7'd7},  '{7'd43,7'd24,7'd22}, '{7'd10,7'd15,7'd67}},
    '{'{7'd19,7'd118,7'd6}, '{7'd18,7'd47,7'd31}, '{7'd34,7'd24,7'd34}, '{7'd20,7'd15,7'd61}}
  };

endpackage

`default_nettype wire

[sv/qci_cfg.sv]
// configuration registers and geometry sequencer: table lookup, products,
// a serial divider for the ec count per block; depends on qci_pkg
`default_nettype none
`include "qr_codeword_interleaver_defines.svh"

module qci_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [5:0]      cfg_wdata_i,
  output logic            busy_o,
  output logic            restart_o,
  output qci_pkg::geom_t  geom_o
);
  import qci_pkg::*;

  localparam int unsigned DivSteps = 12;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam logic [5:0]  VerMax   = 6'(NumVersions - 1);

  typedef enum logic [5:0] {
    CfgRom   = 6'b000001,
    CfgMul   = 6'b000010,
    CfgSum   = 6'b000100,
    CfgDiv   = 6'b001000,
    CfgScale = 6'b010000,
    CfgIdle  = 6'b100000
  } cfg_state_e;

  cfg_state_e           state_q, state_d;
  logic [5:0]           version_q, version_d;
  logic [1:0]           level_q, level_d;
  logic [5:0]           vsel;
  blk_t                 blk;
  logic [6:0]           g1_q, k_q, g2_q;
  logic [11:0]          tot_q;
  logic [13:0]          g1k_q;
  logic [14:0]          g2k_q;
  logic [14:0]          lsum;
  logic [11:0]          l_q;
  logic [7:0]           nb_q;
  logic [11:0]          quo_q, quo_d;
  logic [7:0]           rem_q, rem_d;
  logic [8:0]           trial;
  logic                 trial_ge;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [4:0]           e_q;
  logic [12:0]          nbe_q;

  // register writes
  always_comb begin
    version_d = version_q;
    level_d   = level_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == RegVersion) begin
        version_d = cfg_wdata_i;
      end else begin
        level_d = cfg_wdata_i[1:0];
      end
    end
  end

  // out-of-range versions use the last table row
  assign vsel = (version_q > VerMax) ? VerMax : version_q;
  assign blk  = BlkRom[vsel][level_q];

  assign lsum     = {1'b0, g1k_q} + g2k_q;
  assign trial    = {rem_q, quo_q[11]};
  assign trial_ge = trial >= {1'b0, nb_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      CfgRom:   state_d = CfgMul;
      CfgMul:   state_d = CfgSum;
      CfgSum: begin
        quo_d   = (tot_q > lsum[11:0]) ? (tot_q - lsum[11:0]) : '0;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = CfgDiv;
      end
      CfgDiv: begin
        quo_d = {quo_q[10:0], trial_ge};
        rem_d = trial_ge ? 8'(trial - {1'b0, nb_q}) : trial[7:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = CfgScale;
        end
      end
      CfgScale: state_d = CfgIdle;
      CfgIdle:  state_d = CfgIdle;
      default:  state_d = CfgIdle;
    endcase
    if (cfg_we_i) begin
      state_d = CfgRom;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CfgRom;
      version_q <= '0;
      level_q   <= '0;
    end else begin
      state_q   <= state_d;
      version_q <= version_d;
      level_q   <= level_d;
    end
  end

  // geometry datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (state_q == CfgRom) begin
      g1_q  <= blk.g1;
      k_q   <= blk.k;
      g2_q  <= blk.g2;
      tot_q <= SymTotal[vsel];
    end
    if (state_q == CfgMul) begin
      g1k_q <= {7'b0, g1_q} * {7'b0, k_q};
      g2k_q <= {8'b0, g2_q} * ({8'b0, k_q} + 15'd1);
    end
    if (state_q == CfgSum) begin
      l_q  <= lsum[11:0];
      nb_q <= {1'b0, g1_q} + {1'b0, g2_q};
    end
    // quotient is complete on the last divide step
    if (state_q == CfgDiv && cnt_q == DivCntW'(DivSteps - 1)) begin
      e_q <= (nb_q == 8'd0) ? 5'd0 : quo_d[4:0];
    end
    if (state_q == CfgScale) begin
      nbe_q <= {5'b0, nb_q} * {8'b0, e_q};
    end
  end

  assign busy_o    = (state_q != CfgIdle);
  assign restart_o = cfg_we_i;

  always_comb begin
    geom_o     = '0;
    geom_o.g1  = g1_q;
    geom_o.k   = k_q;
    geom_o.g2  = g2_q;
    geom_o.nb  = nb_q;
    geom_o.g1k = g1k_q[11:0];
    geom_o.l   = l_q;
    geom_o.e   = e_q;
    geom_o.nbe = nbe_q;
  end

  `QCI_ASSERT(a_write_starts_recompute, cfg_we_i |=> busy_o, "config write did not start geometry")

endmodule

`default_nettype wire

[sv/qci_front.sv]
// front end: accepts transactions, keeps write pointers and the read sequence,
// turns in-range writes and every read into a store command; depends on qci_pkg
`default_nettype none

module qci_front #(
  parameter int unsigned StoreDepth = qci_pkg::StoreDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [1:0]       s_op_i,
  input  logic [7:0]       s_byte_i,
  input  logic             busy_i,
  input  logic             restart_i,
  input  qci_pkg::geom_t   geom_i,
  input  logic             full_i,
  output logic             push_o,
  output qci_pkg::cmd_t    cmd_o
);
  import qci_pkg::*;

  localparam logic [12:0] DepthLim = 13'(StoreDepth);

  typedef enum logic [3:0] {
    PhData  = 4'b0001,
    PhExtra = 4'b0010,
    PhEc    = 4'b0100,
    PhRem   = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  row;
    logic [7:0]  blk;
    logic [12:0] base;
  } rd_t;

  phase_e       phase_q, phase_d;
  logic [6:0]   row_q, row_d;
  logic [6:0]   blk_q, blk_d;
  logic [11:0]  base_q, base_d;
  logic [11:0]  dwp_q, dwp_d;
  logic [11:0]  ewp_q, ewp_d;
  rd_t          cur, adv, nxt;
  logic [12:0]  raddr;
  logic         rlast;
  logic [12:0]  ec_addr;
  logic         accept;

  // move past phases that hold no bytes
  function automatic rd_t settle(rd_t s, geom_t g);
    rd_t r;
    r = s;
    if (r.phase == PhData && (r.row >= {1'b0, g.k} || g.nb == 8'd0)) begin
      r.phase = PhExtra;
      r.row   = '0;
      r.blk   = '0;
      r.base  = {1'b0, g.g1k};
    end
    if (r.phase == PhExtra && r.blk >= {1'b0, g.g2}) begin
      r.phase = PhEc;
      r.row   = '0;
      r.blk   = '0;
      r.base  = {1'b0, g.l};
    end
    if (r.phase == PhEc && (r.row >= {3'b0, g.e} || g.nb == 8'd0)) begin
      r.phase = PhRem;
      r.row   = '0;
      r.blk   = '0;
      r.base  = '0;
    end
    return r;
  endfunction

  assign s_ready_o = !busy_i && !full_i;
  assign accept    = s_valid_i && s_ready_o;

  // read sequence step
  always_comb begin
    cur       = settle('{phase_q, {1'b0, row_q}, {1'b0, blk_q}, {1'b0, base_q}}, geom_i);
    adv       = cur;
    raddr     = '0;
    rlast     = 1'b0;
    case (cur.phase)
      PhData: begin
        raddr    = cur.base + {5'b0, cur.row};
        adv.base = cur.base + ((cur.blk < {1'b0, geom_i.g1}) ? {6'b0, geom_i.k}
                                                             : {6'b0, geom_i.k} + 13'd1);
        adv.blk  = cur.blk + 8'd1;
        if (adv.blk >= geom_i.nb) begin
          adv.blk  = '0;
          adv.base = '0;
          adv.row  = cur.row + 8'd1;
        end
      end
      PhExtra: begin
        raddr    = cur.base + {6'b0, geom_i.k};
        adv.base = cur.base + {6'b0, geom_i.k} + 13'd1;
        adv.blk  = cur.blk + 8'd1;
      end
      PhEc: begin
        raddr    = cur.base + {5'b0, cur.row};
        adv.base = cur.base + {8'b0, geom_i.e};
        adv.blk  = cur.blk + 8'd1;
        if (adv.blk >= geom_i.nb) begin
          adv.blk  = '0;
          adv.base = {1'b0, geom_i.l};
          adv.row  = cur.row + 8'd1;
        end
      end
      PhRem: begin
        rlast = 1'b1;
        adv   = '{PhData, 8'd0, 8'd0, 13'd0};
      end
      default: adv = cur;
    endcase
    nxt = rlast ? adv : settle(adv, geom_i);
  end

  assign ec_addr = {1'b0, geom_i.l} + {1'b0, ewp_q};

  // command generation and pointer updates
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    blk_d   = blk_q;
    base_d  = base_q;
    dwp_d   = dwp_q;
    ewp_d   = ewp_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    cmd_o.data = s_byte_i;
    if (accept) begin
      case (opcode_e'(s_op_i))
        OpWrData: begin
          if (dwp_q < geom_i.l) begin
            dwp_d      = dwp_q + 12'd1;
            push_o     = ({1'b0, dwp_q} < DepthLim);
            cmd_o.wr   = 1'b1;
            cmd_o.addr = dwp_q;
          end
        end
        OpWrEc: begin
          if ({1'b0, ewp_q} < geom_i.nbe) begin
            ewp_d      = ewp_q + 12'd1;
            push_o     = (ec_addr < DepthLim);
            cmd_o.wr   = 1'b1;
            cmd_o.addr = ec_addr[11:0];
          end
        end
        OpRead: begin
          push_o     = 1'b1;
          cmd_o.rd   = 1'b1;
          cmd_o.last = rlast;
          cmd_o.zero = rlast || (raddr >= DepthLim);
          cmd_o.addr = raddr[11:0];
          phase_d    = nxt.phase;
          row_d      = nxt.row[6:0];
          blk_d      = nxt.blk[6:0];
          base_d     = nxt.base[11:0];
        end
        OpRestart: begin
          phase_d = PhData;
          row_d   = '0;
          blk_d   = '0;
          base_d  = '0;
          dwp_d   = '0;
          ewp_d   = '0;
        end
        default: push_o = 1'b0;
      endcase
    end
    if (restart_i) begin
      phase_d = PhData;
      row_d   = '0;
      blk_d   = '0;
      base_d  = '0;
      dwp_d   = '0;
      ewp_d   = '0;
    end
  end

  // pointers and read sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhData;
      row_q   <= '0;
      blk_q   <= '0;
      base_q  <= '0;
      dwp_q   <= '0;
      ewp_q   <= '0;
    end else begin
      phase_q <= phase_d;
      row_q   <= row_d;
      blk_q   <= blk_d;
      base_q  <= base_d;
      dwp_q   <= dwp_d;
      ewp_q   <= ewp_d;
    end
  end

endmodule

`default_nettype wire

[sv/qci_fifo.sv]
// short command queue between the front end and the store back end
// depends on qci_pkg for the command type and depth
`default_nettype none

module qci_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qci_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output qci_pkg::cmd_t  cmd_o
);
  import qci_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t             slots_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slots_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[sv/qci_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module qci_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/qci_back.sv]
// back end: carries out store writes and reads, holds results in a
// two-entry output buffer; depends on qci_pkg and qci_ram
`default_nettype none
`include "qr_codeword_interleaver_defines.svh"

module qci_back #(
  parameter int unsigned StoreDepth = qci_pkg::StoreDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  qci_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [7:0]     m_data_o,
  output logic           m_last_o
);
  import qci_pkg::*;

  localparam int unsigned AddrW = $clog2(StoreDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  logic        take;
  logic [2:0]  load;
  logic        credit_ok;
  logic        head_wr, head_rd, issue;
  logic        inf_q, inf_zero_q, inf_last_q;
  logic [7:0]  rdata;
  out_t        land;
  out_t        slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]  occ_q, occ_d;

  assign m_valid_o = (occ_q != 2'd0);
  assign take      = m_valid_o && m_ready_i;

  // a read may issue only if its result will find a free buffer entry
  assign load      = {1'b0, occ_q} + {2'b0, inf_q} - {2'b0, take};
  assign credit_ok = (load < 3'd2);

  assign head_wr = !empty_i && cmd_i.wr;
  assign head_rd = !empty_i && cmd_i.rd;
  assign issue   = head_rd && credit_ok;
  assign pop_o   = head_wr || issue;

  qci_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (head_wr),
    .waddr_i (cmd_i.addr[AddrW-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (issue),
    .raddr_i (cmd_i.addr[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q <= 1'b0;
    end else begin
      inf_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      inf_zero_q <= cmd_i.zero;
      inf_last_q <= cmd_i.last;
    end
  end

  assign land.data = inf_zero_q ? 8'd0 : rdata;
  assign land.last = inf_last_q;

  // output buffer, slot0 drives the port
  always_comb begin
    occ_d   = occ_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case ({take, inf_q})
      2'b01: begin
        if (occ_q == 2'd0) begin
          slot0_d = land;
        end else begin
          slot1_d = land;
        end
        occ_d = occ_q + 2'd1;
      end
      2'b10: begin
        slot0_d = slot1_q;
        occ_d   = occ_q - 2'd1;
      end
      2'b11: begin
        if (occ_q == 2'd1) begin
          slot0_d = land;
        end else begin
          slot0_d = slot1_q;
          slot1_d = land;
        end
      end
      default: occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 2'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign m_data_o = slot0_q.data;
  assign m_last_o = slot0_q.last;

  `QCI_ASSERT_ALWAYS(a_occ_bound, occ_q != 2'd3, "output buffer overfilled")
  `QCI_ASSERT(a_land_has_room, (inf_q && occ_q == 2'd2) |-> take, "read result landed on full buffer")

endmodule

`default_nettype wire

[sv/qr_codeword_interleaver.sv]
// top level of the qr codeword interleaver: configuration, front end,
// command queue and store back end; depends on qci_pkg and all qci_* modules
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tuser: opcode, tdata: byte_in
//  m_axis    out        m_axis_tvalid/tready      tdata: byte_out, tlast: last
//  cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle is accepted once the geometry is ready and the queue is
// not full; after reset and after every configuration write the geometry is rebuilt
// (table lookup, products, 12-step serial divide, ec total); tready is low meanwhile
// a read result passes the command queue, the store read port and the output buffer
// an output stall backs up through the queue; a held read blocks the writes behind it
// the store is not cleared: the user must write entries before reading; not enforced
`default_nettype none
`include "qr_codeword_interleaver_defines.svh"

module qr_codeword_interleaver #(
  parameter int unsigned STORE_DEPTH = qci_pkg::StoreDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] byte_out
  output logic        m_axis_tlast
);
  import qci_pkg::*;

  logic   cfg_busy;
  logic   cfg_restart;
  geom_t  geom;
  logic   q_push, q_full, q_pop, q_empty;
  cmd_t   q_in, q_out;

  // geometry and configuration registers
  qci_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (cfg_busy),
    .restart_o   (cfg_restart),
    .geom_o      (geom)
  );

  // transaction classification and address generation
  qci_front #(
    .StoreDepth (STORE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_op_i    (s_axis_tuser),
    .s_byte_i  (s_axis_tdata),
    .busy_i    (cfg_busy),
    .restart_i (cfg_restart),
    .geom_i    (geom),
    .full_i    (q_full),
    .push_o    (q_push),
    .cmd_o     (q_in)
  );

  // command queue
  qci_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_out)
  );

  // store access and output buffer
  qci_back #(
    .StoreDepth (STORE_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .cmd_i     (q_out),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  `QCI_ASSERT(a_no_accept_while_busy, (s_axis_tvalid && s_axis_tready) |-> !cfg_busy, "transaction accepted during geometry update")

endmodule

`default_nettype wire

[tb/qci_readout_check.sv]
// scoreboard of the qr codeword interleaver: follows the config port and both streams,
// predicts every read result from its own copy of the store and pointers, and compares
// depends on qci_pkg for the opcodes, register indexes and block tables
module qci_readout_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,   // [7:0] byte_in
  input  logic [1:0]  s_user_i,   // [1:0] opcode
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [7:0]  m_data_i,   // [7:0] byte_out
  input  logic        m_last_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned data_len_o,
  output int unsigned ec_len_o
);
  import qci_pkg::*;

  typedef enum logic [1:0] {
    PhData  = 2'd0,
    PhExtra = 2'd1,
    PhEc    = 2'd2,
    PhPad   = 2'd3
  } read_phase_e;

  // block layout of the selected symbol
  typedef struct packed {
    logic [6:0]  g1;
    logic [6:0]  k;
    logic [6:0]  g2;
    logic [7:0]  nb;
    logic [11:0] l;
    logic [11:0] total;
  } layout_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } codeword_t;

  logic [7:0]  cw_mem [StoreDepthDef];
  logic [5:0]  version_q;
  logic [1:0]  level_q;
  layout_t     lay_q;
  logic [4:0]  ec_q;
  logic [11:0] data_ptr;
  logic [11:0] ec_ptr;
  logic [11:0] base_addr;
  logic [6:0]  row;
  logic [6:0]  blk;
  read_phase_e phase;
  codeword_t   pending_codewords [$];

  function automatic layout_t symbol_layout(logic [5:0] ver, logic [1:0] lvl);
    layout_t     lay;
    int unsigned v;
    // versions past the table fold onto the last row
    v = (ver >= NumVersions) ? NumVersions - 1 : ver;
    lay.g1 = BlkRom[v][lvl].g1;
    lay.k  = BlkRom[v][lvl].k;
    lay.g2 = BlkRom[v][lvl].g2;
    lay.nb = lay.g1 + lay.g2;
    lay.l  = lay.g1 * lay.k + lay.g2 * (lay.k + 1);
    lay.total = SymTotal[v];
    return lay;
  endfunction

  function automatic logic [4:0] ec_count(layout_t lay);
    int unsigned q;
    q = 0;
    if (lay.total > lay.l && lay.nb != 0) q = (lay.total - lay.l) / lay.nb;
    return q[4:0];
  endfunction

  task automatic restart_pointers();
    data_ptr  = '0;
    ec_ptr    = '0;
    phase     = PhData;
    row       = '0;
    blk       = '0;
    base_addr = '0;
  endtask

  task automatic apply_config();
    lay_q = symbol_layout(version_q, level_q);
    ec_q  = ec_count(lay_q);
    restart_pointers();
    data_len_o = lay_q.l;
    ec_len_o   = lay_q.nb * ec_q;
  endtask

  // step over phases that hold no bytes
  task automatic skip_empty_phases();
    if (phase == PhData && (row >= lay_q.k || lay_q.nb == 0)) begin
      phase = PhExtra; row = '0; blk = '0; base_addr = lay_q.g1 * lay_q.k;
    end
    if (phase == PhExtra && blk >= lay_q.g2) begin
      phase = PhEc; row = '0; blk = '0; base_addr = lay_q.l;
    end
    if (phase == PhEc && (row >= ec_q || lay_q.nb == 0)) begin
      phase = PhPad; row = '0; blk = '0; base_addr = '0;
    end
  endtask

  // next byte of the interleaved message
  task automatic next_codeword(output codeword_t cw);
    logic [11:0] addr;
    cw = '0;
    skip_empty_phases();
    case (phase)
      PhData: begin
        addr = base_addr + row;
        cw.value = cw_mem[addr];
        base_addr = base_addr + ((blk < lay_q.g1) ? lay_q.k : lay_q.k + 1);
        blk = blk + 1;
        if (blk >= lay_q.nb) begin
          blk = '0; base_addr = '0; row = row + 1;
        end
      end
      PhExtra: begin
        addr = base_addr + lay_q.k;
        cw.value = cw_mem[addr];
        base_addr = base_addr + lay_q.k + 1;
        blk = blk + 1;
      end
      PhEc: begin
        addr = base_addr + row;
        cw.value = cw_mem[addr];
        base_addr = base_addr + ec_q;
        blk = blk + 1;
        if (blk >= lay_q.nb) begin
          blk = '0; base_addr = lay_q.l; row = row + 1;
        end
      end
      default: begin
        // remainder byte, then the read sequence starts over
        cw.last = 1'b1;
        phase = PhData; row = '0; blk = '0; base_addr = '0;
      end
    endcase
    if (!cw.last) skip_empty_phases();
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("qci_readout_check: %0t: %s mismatch, got %0h want %0h", $realtime, what, got,
             want);
    mismatch_count_o++;
  endtask

  // track every transaction at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    codeword_t cw;
    if (!rst_ni) begin
      version_q = '0;
      level_q   = '0;
      apply_config();
      pending_codewords.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegVersion) version_q = cfg_wdata_i;
        else level_q = cfg_wdata_i[1:0];
        apply_config();
      end
      // compare result against the oldest prediction
      if (m_valid_i && m_ready_i) begin
        if (pending_codewords.size() == 0) begin
          report_mismatch("unexpected result", m_data_i, 0);
        end else begin
          cw = pending_codewords.pop_front();
          if (m_data_i !== cw.value) report_mismatch("byte_out", m_data_i, cw.value);
          if (m_last_i !== cw.last) report_mismatch("last", m_last_i, cw.last);
        end
      end
      // accepted input transaction
      if (s_valid_i && s_ready_i) begin
        case (opcode_e'(s_user_i))
          OpWrData: begin
            if (data_ptr < lay_q.l) begin
              cw_mem[data_ptr] = s_data_i;
              data_ptr = data_ptr + 1;
            end
          end
          OpWrEc: begin
            if (ec_ptr < lay_q.nb * ec_q) begin
              cw_mem[lay_q.l + ec_ptr] = s_data_i;
              ec_ptr = ec_ptr + 1;
            end
          end
          OpRead: begin
            next_codeword(cw);
            pending_codewords.push_back(cw);
          end
          default: restart_pointers();
        endcase
      end
      pending_o = pending_codewords.size();
    end
  end

endmodule

[tb/tb_top.sv]
// top of the qr codeword interleaver testbench: clock, reset, config writes and both
// stream sides with random idling; depends on qci_pkg, the block and qci_readout_check
module tb_top;
  import qci_pkg::*;

  localparam int unsigned RandomItems = 600;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned IdleLimit   = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [5:0] cfg_wdata_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] byte_in
  logic [1:0] s_axis_tuser = '0;   // [1:0] opcode
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] byte_out
  logic       m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned data_len;
  int unsigned ec_len;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  always #10 clk_i = ~clk_i;

  qr_codeword_interleaver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  qci_readout_check readout_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_valid_i        (s_axis_tvalid),
    .s_ready_i        (s_axis_tready),
    .s_data_i         (s_axis_tdata),
    .s_user_i         (s_axis_tuser),
    .m_valid_i        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .m_data_i         (m_axis_tdata),
    .m_last_i         (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .data_len_o       (data_len),
    .ec_len_o         (ec_len)
  );

  // offer one transaction, with a random gap first; returns at the falling edge
  task automatic push_item(opcode_e op, logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [5:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // hold the sender until every predicted result is out, then let writes settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // whole data and ec sets of the current symbol, plus some ignored surplus writes
  task automatic load_frame(int unsigned surplus);
    int unsigned n_data;
    int unsigned n_ec;
    n_data = data_len + surplus;
    n_ec   = ec_len + surplus;
    repeat (n_data) push_item(OpWrData, $urandom_range(0, 255));
    repeat (n_ec) push_item(OpWrEc, $urandom_range(0, 255));
  endtask

  task automatic read_pass(int unsigned n);
    repeat (n) push_item(OpRead, $urandom_range(0, 255));
  endtask

  // new symbol for a phase; small versions mostly, level upper bits random
  task automatic pick_config();
    logic [5:0]  ver;
    logic [5:0]  lvl_word;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 65) ver = $urandom_range(0, 1);
    else if (w < 92) ver = $urandom_range(2, 4);
    else ver = $urandom_range(5, 9);
    lvl_word = $urandom_range(0, 63);
    case ($urandom_range(0, 2))
      0: write_reg(RegVersion, ver);
      1: begin
        if (data_len > 600) write_reg(RegVersion, ver);
        write_reg(RegEcLevel, lvl_word);
      end
      default: begin
        write_reg(RegVersion, ver);
        write_reg(RegEcLevel, lvl_word);
      end
    endcase
  endtask

  // mixed opcodes with random content
  task automatic noise_burst();
    int unsigned w;
    opcode_e     op;
    repeat ($urandom_range(20, 40)) begin
      w = $urandom_range(0, 99);
      op = (w < 45) ? OpRead : (w < 70) ? OpWrData : (w < 92) ? OpWrEc : OpRestart;
      push_item(op, $urandom_range(0, 255));
    end
  endtask

  // receiver side: random idling and one long hold-off
  initial begin : rx_drive
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen == HoldAt) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= IdleLimit);
    $display("tb_top: done, errors");
    $finish;
  end

  // stimulus
  initial begin : stim
    int unsigned start_items;
    int unsigned phase_no;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // largest symbol via an out-of-range version; fills every address a read can reach
    write_reg(RegVersion, 6'd63);
    write_reg(RegEcLevel, 6'd0);
    load_frame(3);
    read_pass(data_len + ec_len + 1 + 5);
    drain_results();

    // smallest symbol at level H, restarts while writing and while reading
    write_reg(RegVersion, 6'd0);
    write_reg(RegEcLevel, 6'd3);
    repeat (5) push_item(OpWrData, 8'h00);
    push_item(OpRestart, 8'hff);
    load_frame(2);
    read_pass(10);
    push_item(OpRestart, 8'h00);
    read_pass(data_len + ec_len + 1);
    drain_results();

    // random phases: mostly whole frames and full read passes, some noise
    start_items = items_sent;
    phase_no = 0;
    while (items_sent - start_items < RandomItems) begin
      drain_results();
      calm = (phase_no == 2 || phase_no == 3);
      if ($urandom_range(0, 3) != 0) begin
        pick_config();
        load_frame($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
          read_pass($urandom_range(1, data_len));
          push_item(OpRestart, $urandom_range(0, 255));
        end
        read_pass(data_len + ec_len + 1 + $urandom_range(0, 3));
      end else begin
        if ($urandom_range(0, 4) == 0) write_reg(RegVersion, $urandom_range(40, 63));
        else pick_config();
        noise_burst();
      end
      phase_no++;
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
